/* hdl/slt_pkg.sv */
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 32;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_SEARCH = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_SHOW   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        logic signed [VAL_W-1:0] wdata;
        logic [ADDR_W-1:0]       raddr;
    } mem_req_t;

    typedef struct packed {
        logic                    load;
        logic signed [VAL_W-1:0] value;
        status_t                 status;
        logic                    last;
    } emit_t;

endpackage

/* hdl/slt_if.sv */
interface slt_in_if;
    import slt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [2:0]              action;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface slt_out_if;
    import slt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value_res;
    logic [1:0]              status;
    logic                    last;

    modport source (output valid, output value_res, output status, output last, input ready);
    modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

/* hdl/sorted_list_table.sv */
// Sorted table of up to CAPACITY signed 32-bit values held in one RAM with a registered read
// and a separate write port; one sequencer with a shared compare unit walks the entries, with
// a read state and a compare state per entry visited. Insert into an empty or a full table is
// settled on acceptance; else insert walks down from the top, moving each entry at or above
// the new value up one slot, then writes the new value in the gap. Search reads from the front
// up to the match or the first larger entry; delete finds the entry the same way, then moves
// each later entry down one slot; show and clear read every entry; an output stall holds the
// sequencer. Each item is finished, with its last result loaded into the output register,
// before the next item is accepted. Insert, search and delete give one result echoing the
// operand; show and clear give one result per entry in ascending order, or one empty result
// with value 0 when the table is empty. Action codes 5 to 7 are taken and dropped without a
// result.
module sorted_list_table
    import slt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    slt_in_if.sink           in_ch,
    slt_out_if.source        out_ch
);

    emit_t                   emit;
    mem_req_t                mem_req;
    logic signed [VAL_W-1:0] rd_data;
    logic                    out_free;

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    status_t                 out_status_reg;
    logic                    out_last_reg;

    assign out_free = !out_valid_reg || out_ch.ready;

    slt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .action   (in_ch.action),
        .value    (in_ch.value),
        .out_free (out_free),
        .emit     (emit),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    slt_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_value_reg  <= emit.value;
            out_status_reg <= emit.status;
            out_last_reg   <= emit.last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value_res = out_value_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.last      = out_last_reg;

endmodule

/* hdl/slt_mem.sv */
module slt_mem
    import slt_pkg::*;
(
    input  logic                    clk,
    input  mem_req_t                req,
    output logic signed [VAL_W-1:0] rd_data
);

    logic signed [VAL_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

/* hdl/slt_seq.sv */
module slt_seq
    import slt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              action,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    out_free,
    output emit_t                   emit,
    output mem_req_t                mem_req,
    input  logic signed [VAL_W-1:0] rd_data
);

    seq_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [2:0]              act_reg, act_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    status_t                 status_reg, status_next;

    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] idx_inc;
    logic             last_idx;
    logic             lt;
    logic             eq;

    // shared compare unit: stored entry against operand
    assign lt       = rd_data < val_reg;
    assign eq       = rd_data == val_reg;
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign last_idx = idx_inc == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        act_reg    <= act_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        in_ready      = state_reg == S_IDLE;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[ADDR_W-1:0];
        mem_req.wdata = val_reg;
        mem_req.raddr = idx_reg[ADDR_W-1:0];
        emit.load     = 1'b0;
        emit.value    = rd_data;
        emit.status   = ST_OK;
        emit.last     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = action;
                    val_next    = value;
                    idx_next    = '0;
                    status_next = ST_OK;
                    unique case (action)
                        ACT_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = '0;
                                mem_req.wdata = value;
                                count_next    = count_reg + CNT_W'(1);
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_SEARCH, ACT_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        ACT_SHOW, ACT_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                val_next    = '0;
                                status_next = ST_EMPTY;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_EMIT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                mem_req.raddr = idx_dec[ADDR_W-1:0];
                state_next    = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                mem_req.we = 1'b1;
                if (!lt)
                begin
                    // move entry up one slot
                    mem_req.wdata = rd_data;
                    idx_next      = idx_dec;
                    state_next    = (idx_reg == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_OUT;
                end
            end
            S_INS_PUT:
            begin
                mem_req.we = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_OUT;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (eq)
                begin
                    if (act_reg == ACT_SEARCH)
                    begin
                        state_next = S_OUT;
                    end
                    else if (last_idx)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_DEL_RD;
                    end
                end
                else if (!lt || last_idx)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_DEL_RD:
            begin
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                // move entry down one slot
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_dec[ADDR_W-1:0];
                mem_req.wdata = rd_data;
                if (last_idx)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_DEL_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    emit.load = 1'b1;
                    emit.last = last_idx;
                    if (last_idx)
                    begin
                        if (act_reg == ACT_CLEAR)
                        begin
                            count_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_OUT:
            begin
                emit.value  = val_reg;
                emit.status = status_reg;
                emit.last   = 1'b1;
                if (out_free)
                begin
                    emit.load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* test/sorted_list_table_test.sv */
`timescale 1ns / 100ps

module sorted_list_table_test;
    import slt_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
    localparam int HOLD_AT_REPLY = 120;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        status_t                 status;
        logic                    last;
    } reply_t;

    class sorted_table_mirror;
        logic signed [VAL_W-1:0] entries [CAPACITY];
        int                      count;
        reply_t                  awaited_replies [$];
        int                      mismatches;
        int                      requests;
        int                      ignored;
        int                      replies_checked;
        int                      full_hits;
        int                      empty_lists;
        int                      peak;

        function new();
            count = 0;
            mismatches = 0;
            requests = 0;
            ignored = 0;
            replies_checked = 0;
            full_hits = 0;
            empty_lists = 0;
            peak = 0;
        endfunction

        function void push_reply(logic signed [VAL_W-1:0] v, status_t st, logic lst);
            reply_t r;
            r.value = v;
            r.status = st;
            r.last = lst;
            awaited_replies.push_back(r);
        endfunction

        function void list_all();
            if (count == 0)
            begin
                push_reply('0, ST_EMPTY, 1'b1);
                empty_lists++;
            end
            else
            begin
                for (int i = 0; i < count; i++)
                    push_reply(entries[i], ST_OK, i == count - 1);
            end
        endfunction

        function void note_request(logic [2:0] act, logic signed [VAL_W-1:0] v);
            int pos;
            bit hit;
            requests++;
            case (act)
                ACT_INSERT:
                begin
                    if (count >= CAPACITY)
                    begin
                        push_reply(v, ST_FULL, 1'b1);
                        full_hits++;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < count && entries[pos] < v)
                            pos++;
                        for (int i = count; i > pos; i--)
                            entries[i] = entries[i - 1];
                        entries[pos] = v;
                        count++;
                        if (count > peak)
                            peak = count;
                        push_reply(v, ST_OK, 1'b1);
                    end
                end
                ACT_SEARCH:
                begin
                    hit = 0;
                    for (int i = 0; i < count; i++)
                        if (entries[i] == v)
                            hit = 1;
                    push_reply(v, hit ? ST_OK : ST_NOT_FOUND, 1'b1);
                end
                ACT_DELETE:
                begin
                    pos = 0;
                    while (pos < count && entries[pos] != v)
                        pos++;
                    if (pos >= count)
                        push_reply(v, ST_NOT_FOUND, 1'b1);
                    else
                    begin
                        for (int i = pos; i + 1 < count; i++)
                            entries[i] = entries[i + 1];
                        count--;
                        push_reply(v, ST_OK, 1'b1);
                    end
                end
                ACT_SHOW:
                    list_all();
                ACT_CLEAR:
                begin
                    list_all();
                    count = 0;
                end
                default:
                    ignored++;
            endcase
        endfunction

        function void check_reply(logic signed [VAL_W-1:0] v, logic [1:0] st, logic lst);
            reply_t e;
            replies_checked++;
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: value %0d status %0d last %0b", v, st, lst);
                return;
            end
            e = awaited_replies.pop_front();
            if (v !== e.value || st !== e.status || lst !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"reply mismatch: expected value %0d status %s last %0b, ",
                              "got value %0d status %0d last %0b"},
                             e.value, e.status.name(), e.last, v, st, lst);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left = 0;
    int   cycle_count = 0;

    sorted_table_mirror mirror = new();

    slt_in_if  in_ch ();
    slt_out_if out_ch ();

    sorted_list_table uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off once enough replies have passed
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            mirror.check_reply(out_ch.value_res, out_ch.status, out_ch.last);
            if (mirror.replies_checked == HOLD_AT_REPLY)
                hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [2:0] act, input logic signed [VAL_W-1:0] operand);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.value  <= operand;
        do
            @(posedge clk);
        while (!in_ch.ready);
        mirror.note_request(act, operand);
    endtask

    task automatic wait_for_replies();
        in_ch.valid <= 1'b0;
        while (mirror.awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_operand();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return VAL_W'(int'($urandom_range(20)) - 10);
        if (r < 60)
        begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return VAL_MAX - 1;
                default: return VAL_MAX;
            endcase
        end
        if (r < 75 && mirror.count > 0)
            return mirror.entries[$urandom_range(mirror.count - 1)];
        return $urandom;
    endfunction

    // bursts switch at random between growing, shrinking and mixed traffic
    task automatic random_burst(input int n);
        int         done;
        int         mode;
        int         pick;
        logic [2:0] act;
        done = 0;
        mode = 0;
        while (done < n)
        begin
            if (done % 20 == 0)
                mode = $urandom_range(2);
            pick = $urandom_range(99);
            if (mode == 0)
                act = pick < 70 ? ACT_INSERT : pick < 80 ? ACT_SEARCH : pick < 88 ? ACT_DELETE :
                      pick < 94 ? ACT_SHOW : pick < 97 ? ACT_CLEAR : ACT_SPARE_FIRST;
            else if (mode == 1)
                act = pick < 20 ? ACT_INSERT : pick < 40 ? ACT_SEARCH : pick < 80 ? ACT_DELETE :
                      pick < 90 ? ACT_SHOW : pick < 95 ? ACT_CLEAR : ACT_SPARE_FIRST;
            else
                act = pick < 40 ? ACT_INSERT : pick < 60 ? ACT_SEARCH : pick < 80 ? ACT_DELETE :
                      pick < 90 ? ACT_SHOW : pick < 96 ? ACT_CLEAR : ACT_SPARE_FIRST;
            if (act == ACT_SPARE_FIRST)
                act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
            else
                done++;
            if (act == ACT_INSERT || act == ACT_SEARCH || act == ACT_DELETE)
                send_item(act, pick_operand());
            else
                send_item(act, $urandom);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_SHOW;
        in_ch.value <= '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table cases
        send_item(ACT_SHOW, $urandom);
        send_item(ACT_CLEAR, $urandom);
        send_item(ACT_DELETE, 32'sd3);
        send_item(ACT_SEARCH, 32'sd3);
        // extremes and duplicates
        send_item(ACT_INSERT, VAL_MAX);
        send_item(ACT_INSERT, VAL_MIN);
        send_item(ACT_INSERT, 32'sd0);
        send_item(ACT_INSERT, -32'sd1);
        send_item(ACT_INSERT, 32'sd5);
        send_item(ACT_INSERT, 32'sd5);
        send_item(ACT_INSERT, VAL_MIN);
        send_item(ACT_SEARCH, 32'sd5);
        send_item(ACT_SEARCH, 32'sd4);
        send_item(ACT_SEARCH, VAL_MIN);
        send_item(ACT_SEARCH, VAL_MAX);
        send_item(ACT_DELETE, 32'sd5);
        send_item(ACT_DELETE, 32'sd4);
        send_item(ACT_SPARE_FIRST, $urandom);
        send_item(ACT_SPARE_LAST, $urandom);
        send_item(ACT_SHOW, $urandom);
        send_item(ACT_CLEAR, $urandom);
        send_item(ACT_SHOW, $urandom);
        wait_for_replies();

        send_idle_pct = 8;
        recv_idle_pct = 49;
        repeat (CAPACITY + 2)
            send_item(ACT_INSERT, pick_operand());
        random_burst(90);
        wait_for_replies();

        send_idle_pct = 49;
        recv_idle_pct = 8;
        random_burst(105);
        wait_for_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(95);
        wait_for_replies();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d requests (%0d unused codes), %0d replies checked, %0d mismatches",
                 mirror.requests, mirror.ignored, mirror.replies_checked, mirror.mismatches);
        $display("table full %0d times, empty listings %0d, peak occupancy %0d of %0d",
                 mirror.full_hits, mirror.empty_lists, mirror.peak, CAPACITY);
        if (mirror.mismatches == 0 && mirror.awaited_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
